// ----- design/snp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package snp_pkg;

  // Default limits of one number string.
  localparam int unsigned MantissaDigitsDef = 32;
  localparam int unsigned LineLengthDef     = 64;

  localparam int unsigned CountW   = 7;
  localparam int unsigned ExpMagW  = 17;
  localparam int unsigned ExpValW  = 18;
  localparam int unsigned ExpCntW  = 3;
  localparam logic [ExpCntW-1:0] ExpDigitsMax = 3'd5;

  // Character codes the parser recognizes.
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;

  typedef enum logic [7:0] {
    PhStart = 8'b0000_0001,
    PhInt   = 8'b0000_0010,
    PhFrac  = 8'b0000_0100,
    PhSp1   = 8'b0000_1000,
    PhEKey  = 8'b0001_0000,
    PhSp2   = 8'b0010_0000,
    PhExpS  = 8'b0100_0000,
    PhExpD  = 8'b1000_0000
  } snp_phase_e;

  typedef struct packed {
    snp_phase_e           phase;
    logic [CountW-1:0]    char_total;
    logic [CountW-1:0]    mant_count;
    logic [CountW-1:0]    point_at;
    logic                 point_seen;
    logic                 minus_sign;
    logic [ExpCntW-1:0]   exp_count;
    logic                 exp_minus;
    logic [ExpMagW-1:0]   exp_mag;
    logic                 failed;
  } snp_state_t;

  localparam snp_state_t StateInit = '{
    phase:      PhStart,
    char_total: '0,
    mant_count: '0,
    point_at:   '0,
    point_seen: 1'b0,
    minus_sign: 1'b0,
    exp_count:  '0,
    exp_minus:  1'b0,
    exp_mag:    '0,
    failed:     1'b0
  };

  typedef struct packed {
    logic                      digit_valid;
    logic [3:0]                digit_value;
    logic                      done_res;
    logic                      well_formed;
    logic                      negative;
    logic [CountW-1:0]         digit_count;
    logic [CountW-1:0]         point_position;
    logic signed [ExpValW-1:0] exponent_value;
  } snp_result_t;

endpackage

`default_nettype wire

// ----- design/snp_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Parser state and its one-character update. The result is combinational
// from the current state and the character; the state advances on step_i.
module snp_parse import snp_pkg::*; #(
  parameter int unsigned MANTISSA_DIGITS = MantissaDigitsDef,
  parameter int unsigned LINE_LENGTH     = LineLengthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        last_i,
  output snp_result_t      result_o
);

  localparam logic [CountW-1:0] DigitsMax = CountW'(MANTISSA_DIGITS);
  localparam logic [CountW-1:0] LineMax   = CountW'(LINE_LENGTH);

  snp_state_t st_q, st_d;

  logic                is_digit, is_sign, fail, ok;
  logic [3:0]          digit;
  logic [ExpMagW-1:0]  mag_times_ten;

  assign is_digit = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign digit    = is_digit ? char_code_i[3:0] : 4'd0;
  assign is_sign  = (char_code_i == ChPlus) || (char_code_i == ChMinus);
  assign mag_times_ten = (st_q.exp_mag << 3) + (st_q.exp_mag << 1);

  always_comb begin
    st_d = st_q;
    fail = st_q.failed;
    result_o = '0;

    if (!fail) begin
      if (st_q.char_total >= LineMax) begin
        fail = 1'b1;
      end else begin
        st_d.char_total = st_q.char_total + CountW'(1);
      end
    end

    if (!fail) begin
      unique case (st_q.phase)
        PhStart, PhInt, PhFrac: begin
          if (is_sign && st_q.phase == PhStart) begin
            st_d.minus_sign = (char_code_i == ChMinus);
            st_d.phase      = PhInt;
          end else if (is_digit) begin
            if (st_q.mant_count >= DigitsMax) begin
              fail = 1'b1;
            end else begin
              st_d.mant_count       = st_q.mant_count + CountW'(1);
              result_o.digit_valid = 1'b1;
              result_o.digit_value = digit;
            end
            if (st_q.phase == PhStart) begin
              st_d.phase = PhInt;
            end
          end else if (char_code_i == ChPoint && st_q.phase != PhFrac) begin
            st_d.point_seen = 1'b1;
            st_d.point_at   = st_q.mant_count;
            st_d.phase      = PhFrac;
          end else if (char_code_i == ChSpace && st_q.phase != PhStart) begin
            st_d.phase = PhSp1;
          end else begin
            fail = 1'b1;
          end
        end
        PhSp1: begin
          if (char_code_i == ChLowE || char_code_i == ChUpE) begin
            st_d.phase = PhEKey;
          end else begin
            fail = 1'b1;
          end
        end
        PhEKey: begin
          if (char_code_i == ChSpace) begin
            st_d.phase = PhSp2;
          end else begin
            fail = 1'b1;
          end
        end
        PhSp2, PhExpS, PhExpD: begin
          if (is_sign && st_q.phase == PhSp2) begin
            st_d.exp_minus = (char_code_i == ChMinus);
            st_d.phase     = PhExpS;
          end else if (is_digit) begin
            if (st_q.exp_count >= ExpDigitsMax) begin
              fail = 1'b1;
            end else begin
              st_d.exp_count = st_q.exp_count + ExpCntW'(1);
              st_d.exp_mag   = mag_times_ten + ExpMagW'(digit);
              st_d.phase     = PhExpD;
            end
          end else begin
            fail = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
    end

    st_d.failed = fail;

    ok = last_i && !fail && (st_d.mant_count != '0) &&
         (st_d.phase == PhInt || st_d.phase == PhFrac || st_d.phase == PhExpD);

    result_o.done_res    = last_i;
    result_o.well_formed = ok;
    if (ok) begin
      result_o.negative       = st_d.minus_sign;
      result_o.digit_count    = st_d.mant_count;
      result_o.point_position = st_d.point_seen ? st_d.point_at : st_d.mant_count;
      result_o.exponent_value = st_d.exp_minus ? -$signed({1'b0, st_d.exp_mag})
                                               :  $signed({1'b0, st_d.exp_mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateInit;
    end else if (step_i) begin
      st_q <= last_i ? StateInit : st_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/snp_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result register. It loads whenever it is empty or its item is taken.
module snp_out_reg import snp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire snp_result_t in_data_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output snp_result_t      out_data_o
);

  logic        valid_q;
  snp_result_t data_q;

  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/scientific_number_text_parser.sv -----
// Streaming parser for a decimal number in scientific notation.
// The slave channel takes one ASCII character per item on tdata, with
// tlast set on the final character of a string. The accepted form is
// [sign][digits][.[digits]][ e|E [sign]digits], with single spaces around
// the exponent letter, 1 to MANTISSA_DIGITS mantissa digits, 1 to 5
// exponent digits and at most LINE_LENGTH characters per string.
// The master channel returns exactly one item per character. tuser flags a
// mantissa digit, whose value is in the low tdata bits. On the item for the
// final character (tlast high) the verdict is given, and for a well-formed
// string the sign, digit count, point position and signed exponent; they
// read as zero otherwise. A character is registered at the input, then the
// parser logic and state update run from it into the result register.
// Throughput is one character per cycle while the receiver does not stall.
// While the receiver stalls, the result register holds and one more
// character is held in the input register before tready drops.
// Reset clears both valid flags and returns the parser to its start state.
`timescale 1ns / 1ps
`default_nettype none

module scientific_number_text_parser import snp_pkg::*; #(
  parameter int unsigned MANTISSA_DIGITS = MantissaDigitsDef,
  parameter int unsigned LINE_LENGTH     = LineLengthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  wire logic        s_axis_tlast_i,   // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [3:0] digit_value, [4] well_formed, [5] negative, [12:6] digit_count,
  // [19:13] point_position, [37:20] exponent_value, [39:38] zero
  output logic [39:0]      m_axis_tdata_o,
  output logic             m_axis_tuser_o,   // [0] digit_valid
  output logic             m_axis_tlast_o    // done_res
);

  // Input register: one character waiting for the parser.
  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        advance;
  logic        accept;
  snp_result_t step_res;
  snp_result_t out_res;

  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  // The parser state moves exactly when a character enters the result register.
  snp_parse #(
    .MANTISSA_DIGITS(MANTISSA_DIGITS),
    .LINE_LENGTH    (LINE_LENGTH)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_valid_q && advance),
    .char_code_i(char_q),
    .last_i     (last_q),
    .result_o   (step_res)
  );

  snp_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_data_i  (step_res),
    .advance_o  (advance),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (out_res)
  );

  assign m_axis_tuser_o = out_res.digit_valid;
  assign m_axis_tlast_o = out_res.done_res;
  assign m_axis_tdata_o = {2'b00,
                           out_res.exponent_value,
                           out_res.point_position,
                           out_res.digit_count,
                           out_res.negative,
                           out_res.well_formed,
                           out_res.digit_value};

  // A verdict is only ever given on the final item of a string.
  a_verdict_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !out_res.well_formed)
    else $error("well_formed set on an item that is not the last");

  // A reported digit is a decimal value.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res.digit_valid |-> out_res.digit_value <= 4'd9)
    else $error("digit value out of range");

  // A good string has a digit count within limits and a point inside it.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res.well_formed |->
      (out_res.digit_count != '0) &&
      (out_res.digit_count <= CountW'(MANTISSA_DIGITS)) &&
      (out_res.point_position <= out_res.digit_count))
    else $error("inconsistent digit count or point position");

  // A held input character stays in place until the result register frees up.
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(char_q) && $stable(last_q))
    else $error("input register changed while stalled");

endmodule

`default_nettype wire
